// File: rtl/core/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, widths and codes of the triangle feature classifier.
// ----------------------------------------------------------------------------
package tfc_pkg;

  // coordinates are signed Q12.12
  localparam int unsigned CoordWidth = 24;
  localparam int unsigned TriW       = 31;
  localparam int unsigned DiffW      = CoordWidth + 1;
  localparam int unsigned ProdW      = 2 * DiffW;
  localparam int unsigned DotW       = 2 * CoordWidth + 4;
  localparam int unsigned AccW       = 2 * DotW + 1;

  // cross terms are built one chunk of the right operand per cycle
  localparam int unsigned ChunkW     = 8;
  localparam int unsigned NumChunks  = (DotW + ChunkW - 1) / ChunkW;
  localparam int unsigned PadW       = NumChunks * ChunkW;
  localparam int unsigned ChunkCntW  = $clog2(NumChunks);

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic ActLoad     = 1'b0;
  localparam logic ActClassify = 1'b1;

  localparam logic [1:0] VtxA = 2'd0;
  localparam logic [1:0] VtxB = 2'd1;
  localparam logic [1:0] VtxC = 2'd2;

  typedef enum logic [1:0] {
    KindVertex = 2'd0,
    KindEdge   = 2'd1,
    KindFace   = 2'd2
  } tfc_kind_e;

  localparam logic [1:0] SubVtxA  = 2'd0;
  localparam logic [1:0] SubVtxB  = 2'd1;
  localparam logic [1:0] SubVtxC  = 2'd2;
  localparam logic [1:0] SubEdgeAb = 2'd0;
  localparam logic [1:0] SubEdgeBc = 2'd1;
  localparam logic [1:0] SubEdgeCa = 2'd2;
  localparam logic [1:0] SubFace  = 2'd0;

  typedef logic [DiffW-1:0] diff_t;

  typedef struct packed {
    logic                         action;
    logic [1:0]                   vertex_select;
    logic signed [CoordWidth-1:0] coord_x;
    logic signed [CoordWidth-1:0] coord_y;
    logic signed [CoordWidth-1:0] coord_z;
    logic [TriW-1:0]              triangle_id;
  } tfc_in_t;

  typedef struct packed {
    tfc_kind_e       feature_kind;
    logic [1:0]      feature_sub;
    logic [TriW-1:0] result_triangle;
  } tfc_out_t;

  // edge and offset vectors of one queued classify request
  typedef struct packed {
    diff_t [2:0]     ab;
    diff_t [2:0]     ac;
    diff_t [2:0]     ap;
    diff_t [2:0]     bp;
    diff_t [2:0]     cp;
    logic [TriW-1:0] tri_id;
  } tfc_job_t;

  typedef struct packed {
    logic start;
    logic step;
    logic first;
  } tfc_xctl_t;

  function automatic diff_t sub_coord(input logic [CoordWidth-1:0] a,
                                      input logic [CoordWidth-1:0] b);
    return {a[CoordWidth-1], a} - {b[CoordWidth-1], b};
  endfunction

endpackage

// File: rtl/core/tfc_front.sv
// ----------------------------------------------------------------------------
// tfc_front
// Holds the triangle vertices, executes loads and turns a classify request
// into edge and offset vectors for the back end queue.
// ----------------------------------------------------------------------------
module tfc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  tfc_pkg::tfc_in_t  in_data_i,
  output logic              in_stall_o,
  input  logic              full_i,
  output logic              push_o,
  output tfc_pkg::tfc_job_t job_o
);
  import tfc_pkg::*;

  logic [CoordWidth-1:0] vtx_q [3][3];
  logic [CoordWidth-1:0] pt    [3];
  logic                  accept;
  logic [2:0]            wr_en;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && (in_data_i.action == ActClassify);

  assign pt[0] = in_data_i.coord_x;
  assign pt[1] = in_data_i.coord_y;
  assign pt[2] = in_data_i.coord_z;

  // a select of three writes nothing
  always_comb begin
    wr_en[0] = accept && (in_data_i.action == ActLoad) && (in_data_i.vertex_select == VtxA);
    wr_en[1] = accept && (in_data_i.action == ActLoad) && (in_data_i.vertex_select == VtxB);
    wr_en[2] = accept && (in_data_i.action == ActLoad) && (in_data_i.vertex_select == VtxC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < 3; v++) begin
        for (int a = 0; a < 3; a++) begin
          vtx_q[v][a] <= '0;
        end
      end
    end else begin
      for (int v = 0; v < 3; v++) begin
        if (wr_en[v]) begin
          for (int a = 0; a < 3; a++) begin
            vtx_q[v][a] <= pt[a];
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      job_o.ab[a] = sub_coord(vtx_q[1][a], vtx_q[0][a]);
      job_o.ac[a] = sub_coord(vtx_q[2][a], vtx_q[0][a]);
      job_o.ap[a] = sub_coord(pt[a], vtx_q[0][a]);
      job_o.bp[a] = sub_coord(pt[a], vtx_q[1][a]);
      job_o.cp[a] = sub_coord(pt[a], vtx_q[2][a]);
    end
    job_o.tri_id = in_data_i.triangle_id;
  end

endmodule

// File: rtl/core/tfc_queue.sv
// ----------------------------------------------------------------------------
// tfc_queue
// Small first-in first-out buffer of classify requests between the front
// and the back end.
// ----------------------------------------------------------------------------
module tfc_queue #(
  parameter int unsigned QueueDepth = tfc_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tfc_pkg::tfc_job_t push_data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output tfc_pkg::tfc_job_t pop_data_o
);
  import tfc_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  tfc_job_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/tfc_cross.sv
// ----------------------------------------------------------------------------
// tfc_cross
// Chunked multiply-accumulate unit forming a1*b1 - a2*b2 exactly, one chunk
// of the right operands per cycle, most significant chunk first.
// ----------------------------------------------------------------------------
module tfc_cross (
  input  logic                              clk_i,
  input  tfc_pkg::tfc_xctl_t                ctl_i,
  input  logic signed [tfc_pkg::DotW-1:0]   a1_i,
  input  logic signed [tfc_pkg::DotW-1:0]   a2_i,
  input  logic signed [tfc_pkg::DotW-1:0]   b1_i,
  input  logic signed [tfc_pkg::DotW-1:0]   b2_i,
  output logic signed [tfc_pkg::AccW-1:0]   acc_o
);
  import tfc_pkg::*;

  logic [PadW-1:0]            b1_q, b2_q;
  logic signed [AccW-1:0]     acc_q, acc_d;
  logic signed [ChunkW:0]     ext1, ext2;
  logic signed [DotW+ChunkW:0] p1, p2;

  // top chunk carries the sign, the rest are unsigned
  always_comb begin
    ext1 = ctl_i.first ? {b1_q[PadW-1], b1_q[PadW-1 -: ChunkW]}
                       : {1'b0, b1_q[PadW-1 -: ChunkW]};
    ext2 = ctl_i.first ? {b2_q[PadW-1], b2_q[PadW-1 -: ChunkW]}
                       : {1'b0, b2_q[PadW-1 -: ChunkW]};
  end

  assign p1    = a1_i * ext1;
  assign p2    = a2_i * ext2;
  assign acc_d = (acc_q <<< ChunkW) + AccW'(p1) - AccW'(p2);
  assign acc_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      b1_q  <= PadW'(b1_i);
      b2_q  <= PadW'(b2_i);
      acc_q <= '0;
    end else if (ctl_i.step) begin
      b1_q  <= b1_q << ChunkW;
      b2_q  <= b2_q << ChunkW;
      acc_q <= acc_d;
    end
  end

endmodule

// File: rtl/core/tfc_back.sv
// ----------------------------------------------------------------------------
// tfc_back
// Back end: dot products, cross terms and the ordered region tests, with an
// output register towards the result channel.
// ----------------------------------------------------------------------------
module tfc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  tfc_pkg::tfc_job_t job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfc_pkg::tfc_out_t out_data_o
);
  import tfc_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSum    = 3'd1;
  localparam logic [2:0] StCross  = 3'd2;
  localparam logic [2:0] StDecide = 3'd3;

  logic [2:0]             state_q, state_d;
  logic [ChunkCntW-1:0]   cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  tfc_out_t               out_q;
  logic [TriW-1:0]        tri_q;

  logic signed [ProdW-1:0] prod_d [6][3];
  logic signed [ProdW-1:0] prod_q [6][3];
  logic signed [DotW-1:0]  d_d [6];
  logic signed [DotW-1:0]  d_q [6];
  logic signed [AccW-1:0]  vc, vb, va;
  logic signed [DotW:0]    s43, s56;

  tfc_xctl_t  xctl;
  tfc_kind_e  kind;
  logic [1:0] sub;
  logic       out_free;
  logic       last_chunk;

  // edges ab and ac against offsets ap, bp and cp give d1 to d6
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int a = 0; a < 3; a++) begin
        unique case (p)
          0: begin
            prod_d[2*p][a]   = $signed(job_i.ab[a]) * $signed(job_i.ap[a]);
            prod_d[2*p+1][a] = $signed(job_i.ac[a]) * $signed(job_i.ap[a]);
          end
          1: begin
            prod_d[2*p][a]   = $signed(job_i.ab[a]) * $signed(job_i.bp[a]);
            prod_d[2*p+1][a] = $signed(job_i.ac[a]) * $signed(job_i.bp[a]);
          end
          default: begin
            prod_d[2*p][a]   = $signed(job_i.ab[a]) * $signed(job_i.cp[a]);
            prod_d[2*p+1][a] = $signed(job_i.ac[a]) * $signed(job_i.cp[a]);
          end
        endcase
      end
    end
    for (int k = 0; k < 6; k++) begin
      d_d[k] = DotW'(prod_q[k][0]) + DotW'(prod_q[k][1]) + DotW'(prod_q[k][2]);
    end
  end

  assign last_chunk = (cnt_q == ChunkCntW'(NumChunks - 1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign job_pop_o  = (state_q == StIdle) && job_valid_i;

  always_comb begin
    xctl.start = (state_q == StSum);
    xctl.step  = (state_q == StCross);
    xctl.first = (cnt_q == '0);
  end

  // vc = d1*d4 - d3*d2
  tfc_cross u_cross_c (
    .clk_i (clk_i),
    .ctl_i (xctl),
    .a1_i  (d_q[0]),
    .a2_i  (d_q[2]),
    .b1_i  (d_d[3]),
    .b2_i  (d_d[1]),
    .acc_o (vc)
  );

  // vb = d5*d2 - d1*d6
  tfc_cross u_cross_b (
    .clk_i (clk_i),
    .ctl_i (xctl),
    .a1_i  (d_q[4]),
    .a2_i  (d_q[0]),
    .b1_i  (d_d[1]),
    .b2_i  (d_d[5]),
    .acc_o (vb)
  );

  // va = d3*d6 - d5*d4
  tfc_cross u_cross_a (
    .clk_i (clk_i),
    .ctl_i (xctl),
    .a1_i  (d_q[2]),
    .a2_i  (d_q[4]),
    .b1_i  (d_d[5]),
    .b2_i  (d_d[3]),
    .acc_o (va)
  );

  assign s43 = {d_q[3][DotW-1], d_q[3]} - {d_q[2][DotW-1], d_q[2]};
  assign s56 = {d_q[4][DotW-1], d_q[4]} - {d_q[5][DotW-1], d_q[5]};

  // first test that holds wins
  always_comb begin
    kind = KindFace;
    sub  = SubFace;
    priority if ((d_q[0][DotW-1] || d_q[0] == '0) && (d_q[1][DotW-1] || d_q[1] == '0)) begin
      kind = KindVertex;
      sub  = SubVtxA;
    end else if (!d_q[2][DotW-1] && (s43[DotW] || s43 == '0)) begin
      kind = KindVertex;
      sub  = SubVtxB;
    end else if ((vc[AccW-1] || vc == '0) && !d_q[0][DotW-1]
                 && (d_q[2][DotW-1] || d_q[2] == '0)) begin
      kind = KindEdge;
      sub  = SubEdgeAb;
    end else if (!d_q[5][DotW-1] && (s56[DotW] || s56 == '0)) begin
      kind = KindVertex;
      sub  = SubVtxC;
    end else if ((vb[AccW-1] || vb == '0) && !d_q[1][DotW-1]
                 && (d_q[5][DotW-1] || d_q[5] == '0)) begin
      kind = KindEdge;
      sub  = SubEdgeCa;
    end else if ((va[AccW-1] || va == '0) && !s43[DotW] && !s56[DotW]) begin
      kind = KindEdge;
      sub  = SubEdgeBc;
    end else begin
      kind = KindFace;
      sub  = SubFace;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          state_d = StSum;
        end
      end
      StSum: begin
        state_d = StCross;
        cnt_d   = '0;
      end
      StCross: begin
        cnt_d = cnt_q + 1'b1;
        if (last_chunk) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (out_free) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      prod_q <= prod_d;
      tri_q  <= job_i.tri_id;
    end
    if (state_q == StSum) begin
      d_q <= d_d;
    end
    if (state_q == StDecide && out_free) begin
      out_q.feature_kind    <= kind;
      out_q.feature_sub     <= sub;
      out_q.result_triangle <= tri_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/triangle_feature_classifier_unit.sv
// ----------------------------------------------------------------------------
// triangle_feature_classifier_unit
// Closest-feature test of a point against a stored triangle.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with one tfc_in_t request. A load
// request (action 0) writes vertex a, b or c and gives no result; a classify
// request (action 1) gives exactly one result on out_valid_o / out_stall_i,
// naming the vertex, edge or face of the triangle nearest to the point.
// Loads are taken one per cycle while the queue is not full. A classify
// request enters a queue of QueueDepth entries and the back end then
// forms the edge products, then the dot sums, then the cross terms in the
// three cross-term units that consume one 8-bit chunk per cycle, and then
// registers the result. The back end works on one classify at a time and
// takes no new one from the queue until its result is registered.
// A stalled result stays in the output register; the back end holds its
// finished item, the queue fills and then in_stall_o rises.
// Reset clears all vertices to zero and empties the queue and output.
// ----------------------------------------------------------------------------
module triangle_feature_classifier_unit #(
  parameter int unsigned QueueDepth = tfc_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tfc_pkg::tfc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfc_pkg::tfc_out_t out_data_o
);
  import tfc_pkg::*;

  logic     push, full, job_valid, job_pop;
  tfc_job_t push_job, head_job;

  tfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  tfc_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .valid_o     (job_valid),
    .pop_i       (job_pop),
    .pop_data_o  (head_job)
  );

  tfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
